// ----- rtl/cer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_pkg
// Codes and fixed widths shared by the cell edit undo ring.
// ----------------------------------------------------------------------------
package cer_pkg;

    localparam int ACTION_BITS = 2;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int TIME_BITS   = 32;

    typedef logic [ACTION_BITS-1:0] t_action;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [KIND_BITS-1:0]   t_kind;
    typedef logic [TIME_BITS-1:0]   t_time;

    localparam t_action ACT_RECORD = 2'd0;
    localparam t_action ACT_UNDO   = 2'd1;
    localparam t_action ACT_REDO   = 2'd2;

    localparam t_status ST_PUSHED  = 3'd0;
    localparam t_status ST_MERGED  = 3'd1;
    localparam t_status ST_DROPPED = 3'd2;
    localparam t_status ST_IGNORED = 3'd3;
    localparam t_status ST_APPLIED = 3'd4;
    localparam t_status ST_NOTHING = 3'd5;

endpackage

// ----- rtl/cer_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_in_if
// Input channel of the undo ring: one edit, undo or redo request per beat.
// ----------------------------------------------------------------------------
interface cer_in_if
    import cer_pkg::*;
#(
    parameter int COORD_BITS = 8,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    t_action               action;
    t_kind                 cell_kind;
    logic [COORD_BITS-1:0] coord_a;
    logic [COORD_BITS-1:0] coord_b;
    logic [VALUE_BITS-1:0] old_value;
    logic [VALUE_BITS-1:0] new_value;
    t_time                 frame_time;

    modport source (
        output valid, action, cell_kind, coord_a, coord_b, old_value, new_value,
               frame_time,
        input  ready
    );
    modport sink (
        input  valid, action, cell_kind, coord_a, coord_b, old_value, new_value,
               frame_time,
        output ready
    );
endinterface

// ----- rtl/cer_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_out_if
// Result channel of the undo ring: one status and write-back per beat.
// ----------------------------------------------------------------------------
interface cer_out_if
    import cer_pkg::*;
#(
    parameter int COORD_BITS = 8,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic                  apply_write;
    t_kind                 kind_out;
    logic [COORD_BITS-1:0] coord_a_out;
    logic [COORD_BITS-1:0] coord_b_out;
    logic [VALUE_BITS-1:0] write_value;

    modport source (
        output valid, status, apply_write, kind_out, coord_a_out, coord_b_out,
               write_value,
        input  ready
    );
    modport sink (
        input  valid, status, apply_write, kind_out, coord_a_out, coord_b_out,
               write_value,
        output ready
    );
endinterface

// ----- rtl/cer_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/cell_edit_undo_ring.sv -----
`timescale 1ns / 1ps
// A request is accepted in S_IDLE while the history record is read from RAM; the result
// is then computed in S_EXEC and registered into the output registers behind o_out.
// The next request is taken only once the last is done (read-then-write of the RAM).
// A result not yet taken holds the block in S_EXEC until that beat is taken.
// Reset empties the history (pointers and depths cleared) and clears the window;
// the RAM itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// cell_edit_undo_ring
// Undo/redo history of single cell edits kept in a RAM ring of DEPTH records.
// ----------------------------------------------------------------------------
module cell_edit_undo_ring
    import cer_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32,
    parameter int COORD_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    cer_in_if.sink      i_in,
    cer_out_if.source   o_out
);
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int KEY_W  = KIND_BITS + 2 * COORD_BITS;
    localparam int WORD_W = KEY_W + 2 * VALUE_BITS + TIME_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL     = CW'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  r_state, n_state;
    logic [AW-1:0]         r_next, n_next;
    logic [CW-1:0]         r_undo, n_undo;
    logic [CW-1:0]         r_redo, n_redo;
    logic [TIME_BITS-1:0]  r_window;
    logic [AW-1:0]         r_slot;

    t_action               r_act;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_old;
    logic [VALUE_BITS-1:0] r_new;
    t_time                 r_time;

    logic                  r_ovalid;
    t_status               r_status, n_status;
    logic                  r_apply, n_apply;
    logic [KEY_W-1:0]      r_okey, n_okey;
    logic [VALUE_BITS-1:0] r_wval, n_wval;

    logic                  accept;
    logic                  exec_go;
    logic [AW-1:0]         prev_slot;
    logic [AW-1:0]         after_slot;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [WORD_W-1:0]     rd_data;

    logic [KEY_W-1:0]      rec_key;
    logic [VALUE_BITS-1:0] rec_before;
    logic [VALUE_BITS-1:0] rec_after;
    t_time                 rec_time;
    t_time                 gap;
    logic                  can_merge;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_ovalid || o_out.ready);

    assign prev_slot  = (r_next == '0) ? LAST_SLOT : r_next - 1'b1;
    assign after_slot = (r_next == LAST_SLOT) ? '0 : r_next + 1'b1;
    // Redo reads the slot after the newest record; everything else reads the newest.
    assign rd_addr    = (i_in.action == ACT_REDO) ? r_next : prev_slot;

    cer_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign {rec_key, rec_before, rec_after, rec_time} = rd_data;
    assign gap       = r_time - rec_time;
    assign can_merge = (r_undo != '0) && (r_redo == '0) && (rec_key == r_key)
                       && (gap <= r_window);

    always_comb begin
        n_state  = r_state;
        n_next   = r_next;
        n_undo   = r_undo;
        n_redo   = r_redo;
        n_status = ST_IGNORED;
        n_apply  = 1'b0;
        n_okey   = '0;
        n_wval   = '0;
        wr_en    = 1'b0;
        wr_addr  = r_next;
        wr_data  = {r_key, r_old, r_new, r_time};

        if (accept) begin
            n_state = S_EXEC;
        end

        if (exec_go) begin
            n_state = S_IDLE;
            case (r_act)
                ACT_RECORD: begin
                    if (r_old == r_new) begin
                        n_status = ST_IGNORED;
                    end else if (can_merge) begin
                        wr_en   = 1'b1;
                        wr_addr = r_slot;
                        wr_data = {rec_key, rec_before, r_new, r_time};
                        if (rec_before == r_new) begin
                            n_status = ST_DROPPED;
                            n_next   = r_slot;
                            n_undo   = r_undo - 1'b1;
                        end else begin
                            n_status = ST_MERGED;
                        end
                    end else begin
                        wr_en    = 1'b1;
                        n_status = ST_PUSHED;
                        n_next   = after_slot;
                        n_redo   = '0;
                        if (r_undo != FULL) begin
                            n_undo = r_undo + 1'b1;
                        end
                    end
                end
                ACT_UNDO: begin
                    if (r_undo == '0) begin
                        n_status = ST_NOTHING;
                    end else begin
                        n_status = ST_APPLIED;
                        n_apply  = 1'b1;
                        n_okey   = rec_key;
                        n_wval   = rec_before;
                        n_next   = r_slot;
                        n_undo   = r_undo - 1'b1;
                        n_redo   = r_redo + 1'b1;
                    end
                end
                ACT_REDO: begin
                    if (r_redo == '0) begin
                        n_status = ST_NOTHING;
                    end else begin
                        n_status = ST_APPLIED;
                        n_apply  = 1'b1;
                        n_okey   = rec_key;
                        n_wval   = rec_after;
                        n_next   = after_slot;
                        n_undo   = r_undo + 1'b1;
                        n_redo   = r_redo - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= '0;
            r_undo   <= '0;
            r_redo   <= '0;
            r_window <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_undo  <= n_undo;
            r_redo  <= n_redo;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (exec_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_in.action;
            r_key  <= {i_in.cell_kind, i_in.coord_a, i_in.coord_b};
            r_old  <= i_in.old_value;
            r_new  <= i_in.new_value;
            r_time <= i_in.frame_time;
            r_slot <= rd_addr;
        end
        if (exec_go) begin
            r_status <= n_status;
            r_apply  <= n_apply;
            r_okey   <= n_okey;
            r_wval   <= n_wval;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_status;
    assign o_out.apply_write = r_apply;
    assign {o_out.kind_out, o_out.coord_a_out, o_out.coord_b_out} = r_okey;
    assign o_out.write_value = r_wval;
endmodule
